@@ sv/rpa_pkg.sv @@
package rpa_pkg;

  // block constants
  localparam int MAX_SIDE  = 1024;
  localparam int FRAC_BITS = 14;

  // field widths
  localparam int COORD_W = 10;
  localparam int PIXEL_W = 32;
  localparam int ADDR_W  = 20;
  localparam int TRIG_W  = 16;
  localparam int SIDE_W  = 11;
  localparam int DATA_W  = 16;
  localparam int INDEX_W = 3;

  // register indexes
  localparam logic [INDEX_W-1:0] REG_COSINE        = 3'd0;
  localparam logic [INDEX_W-1:0] REG_SINE          = 3'd1;
  localparam logic [INDEX_W-1:0] REG_IMAGE_WIDTH   = 3'd2;
  localparam logic [INDEX_W-1:0] REG_IMAGE_HEIGHT  = 3'd3;
  localparam logic [INDEX_W-1:0] REG_WINDOW_WIDTH  = 3'd4;
  localparam logic [INDEX_W-1:0] REG_WINDOW_HEIGHT = 3'd5;

  // reset values
  localparam logic signed [TRIG_W-1:0] COSINE_RESET = 16'sd16384;
  localparam logic signed [TRIG_W-1:0] SINE_RESET   = 16'sd0;
  localparam logic [SIDE_W-1:0]        SIDE_RESET   = 11'd1024;

  typedef struct packed {
    logic [COORD_W-1:0] src_x;
    logic [COORD_W-1:0] src_y;
    logic [PIXEL_W-1:0] src_pixel;
  } in_item_t;

  typedef struct packed {
    logic [ADDR_W-1:0]  write_address;
    logic [PIXEL_W-1:0] dest_pixel;
    logic               write_enable;
  } out_item_t;

  // clamp a size register to the largest supported side
  function automatic logic [SIDE_W-1:0] sat_side(input logic [SIDE_W-1:0] v);
    logic [SIDE_W-1:0] lim;
    lim = SIDE_W'(MAX_SIDE);
    return (v > lim) ? lim : v;
  endfunction

endpackage

@@ sv/rotated_pixel_address_unit.sv @@
// Rotated pixel address unit: maps a source pixel position to a frame buffer
// address after rotation about the image center.
// Input: a pixel transaction (column, row, color word) is taken at a clock
// edge with start high and busy low. busy is low except during reset, so a
// new transaction can be issued every clock.
// Output: each transaction gives one result on the result port, marked by
// done for exactly one cycle. done is driven from the last of six register
// stages (offsets, four products, sums, truncation, row multiply and add,
// final add and bounds compare). Throughput is one pixel per clock, set by
// the fully pipelined datapath.
// The receiver cannot stall; results are never held or repeated.
// Configuration: cfg_we, cfg_index and cfg_data write one register per edge,
// only while no pixels are in flight; the user must ensure this, the block
// doesn't. Centering offset and window area update the cycle after a write.
// Reset (rst, synchronous) empties the pipeline and restores cosine 1.0,
// sine 0 and all sizes to 1024.
module rotated_pixel_address_unit
  import rpa_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  in_item_t            item,
  output logic                done,
  output out_item_t           result,
  input  logic                cfg_we,
  input  logic [INDEX_W-1:0]  cfg_index,
  input  logic [DATA_W-1:0]   cfg_data
);

  localparam int D_W   = SIDE_W + 2;
  localparam int P_W   = TRIG_W + D_W;
  localparam int N_W   = P_W + 2;
  localparam int SH    = FRAC_BITS + 1;
  localparam int T_W   = N_W - SH;
  localparam int M_W   = T_W + SIDE_W + 1;
  localparam int A_W   = M_W + 2;
  localparam int OFF_W = 2 * SIDE_W;

  // configuration registers
  logic signed [TRIG_W-1:0] cosine;
  logic signed [TRIG_W-1:0] sine;
  logic [SIDE_W-1:0] image_width;
  logic [SIDE_W-1:0] image_height;
  logic [SIDE_W-1:0] window_width;
  logic [SIDE_W-1:0] window_height;

  logic [SIDE_W-1:0] iw_s, ih_s, ww_s, wh_s;
  logic [SIDE_W-1:0] half_dw, half_dh;

  // derived from configuration
  logic [OFF_W-1:0] offset;
  logic [OFF_W-1:0] area;
  logic             oversize;

  // pipeline registers
  logic v1, v2, v3, v4, v5, v6;
  logic signed [D_W-1:0] dx2, dy2;
  logic [PIXEL_W-1:0] pix1, pix2, pix3, pix4, pix5;
  logic signed [P_W-1:0] cx, sy, sx, cy;
  logic signed [N_W-1:0] nx, ny;
  logic signed [N_W-1:0] nx_adj, ny_adj;
  logic signed [T_W-1:0] tx, ty;
  logic signed [M_W-1:0] row_base;
  logic signed [A_W-1:0] col_part;
  logic signed [A_W-1:0] addr;
  logic                  en;
  out_item_t             result_next;

  assign busy = rst;
  assign done = v6;

  always_ff @(posedge clk) begin
    if (rst) begin
      cosine        <= COSINE_RESET;
      sine          <= SINE_RESET;
      image_width   <= SIDE_RESET;
      image_height  <= SIDE_RESET;
      window_width  <= SIDE_RESET;
      window_height <= SIDE_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_COSINE:        cosine        <= $signed(cfg_data[TRIG_W-1:0]);
        REG_SINE:          sine          <= $signed(cfg_data[TRIG_W-1:0]);
        REG_IMAGE_WIDTH:   image_width   <= cfg_data[SIDE_W-1:0];
        REG_IMAGE_HEIGHT:  image_height  <= cfg_data[SIDE_W-1:0];
        REG_WINDOW_WIDTH:  window_width  <= cfg_data[SIDE_W-1:0];
        REG_WINDOW_HEIGHT: window_height <= cfg_data[SIDE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    iw_s    = sat_side(image_width);
    ih_s    = sat_side(image_height);
    ww_s    = sat_side(window_width);
    wh_s    = sat_side(window_height);
    // only meaningful when the image fits; otherwise writes are masked
    half_dw = (ww_s - iw_s) >> 1;
    half_dh = (wh_s - ih_s) >> 1;
  end

  always_ff @(posedge clk) begin
    offset   <= OFF_W'(half_dh) * OFF_W'(ww_s) + OFF_W'(half_dw);
    area     <= OFF_W'(ww_s) * OFF_W'(wh_s);
    oversize <= (iw_s > ww_s) || (ih_s > wh_s);
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      v6 <= 1'b0;
    end else begin
      v1 <= start && !busy;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
      v6 <= v5;
    end
  end

  // round toward zero: bias negative sums before the arithmetic shift
  always_comb begin
    nx_adj = nx + (nx[N_W-1] ? N_W'((1 << SH) - 1) : '0);
    ny_adj = ny + (ny[N_W-1] ? N_W'((1 << SH) - 1) : '0);
  end

  always_ff @(posedge clk) begin
    // stage 1: doubled offsets from center
    dx2  <= $signed({2'b00, item.src_x, 1'b0}) - $signed({2'b00, iw_s});
    dy2  <= $signed({2'b00, item.src_y, 1'b0}) - $signed({2'b00, ih_s});
    pix1 <= item.src_pixel;
    // stage 2: rotation products
    cx   <= P_W'(cosine) * P_W'(dx2);
    sy   <= P_W'(sine) * P_W'(dy2);
    sx   <= P_W'(sine) * P_W'(dx2);
    cy   <= P_W'(cosine) * P_W'(dy2);
    pix2 <= pix1;
    // stage 3: sums with the center added back
    nx   <= N_W'(cx) - N_W'(sy) + N_W'($signed({1'b0, iw_s, {FRAC_BITS{1'b0}}}));
    ny   <= N_W'(sx) + N_W'(cy) + N_W'($signed({1'b0, ih_s, {FRAC_BITS{1'b0}}}));
    pix3 <= pix2;
    // stage 4: truncated coordinates
    tx   <= nx_adj[N_W-1 -: T_W];
    ty   <= ny_adj[N_W-1 -: T_W];
    pix4 <= pix3;
    // stage 5: row base and column part
    row_base <= M_W'(ty) * M_W'($signed({1'b0, ww_s}));
    col_part <= A_W'(tx) + A_W'($signed({1'b0, offset}));
    pix5     <= pix4;
    // stage 6: result
    result   <= result_next;
  end

  always_comb begin
    addr = A_W'(row_base) + col_part;
    en   = !oversize && !addr[A_W-1] &&
           (addr < $signed({{(A_W - OFF_W){1'b0}}, area}));
    result_next.write_address = en ? addr[ADDR_W-1:0] : '0;
    result_next.dest_pixel    = pix5;
    result_next.write_enable  = en;
  end

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 100ps

module testbench;
  import rpa_pkg::*;

  // indexes past the last register, writes there must be dropped
  localparam logic [INDEX_W-1:0] REG_SPARE_A = 3'd6;
  localparam logic [INDEX_W-1:0] REG_SPARE_B = 3'd7;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                start = 1'b0;
  logic                busy;
  in_item_t            item = '0;
  logic                done;
  out_item_t           result;
  logic                cfg_we = 1'b0;
  logic [INDEX_W-1:0]  cfg_index = '0;
  logic [DATA_W-1:0]   cfg_data = '0;

  // local copy of the register file
  logic signed [TRIG_W-1:0] rot_cos = COSINE_RESET;
  logic signed [TRIG_W-1:0] rot_sin = SINE_RESET;
  logic [SIDE_W-1:0]        img_w = SIDE_RESET;
  logic [SIDE_W-1:0]        img_h = SIDE_RESET;
  logic [SIDE_W-1:0]        win_w = SIDE_RESET;
  logic [SIDE_W-1:0]        win_h = SIDE_RESET;

  out_item_t expected_writes[$];
  int        mismatch_count = 0;

  rotated_pixel_address_unit u_dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .item      (item),
    .done      (done),
    .result    (result),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic longint clamp_side(logic [SIDE_W-1:0] v);
    longint w;
    w = longint'(v);
    return (w > MAX_SIDE) ? longint'(MAX_SIDE) : w;
  endfunction

  function automatic longint shift_toward_zero(longint n);
    if (n < 0) return -((-n) >> (FRAC_BITS + 1));
    return n >> (FRAC_BITS + 1);
  endfunction

  function automatic out_item_t predict_write(in_item_t px);
    longint c, s, iw, ih, ww, wh, dx2, dy2, nx, ny, tx, ty, off, addr;
    bit en;
    out_item_t r;
    c = longint'(rot_cos);
    s = longint'(rot_sin);
    iw = clamp_side(img_w);
    ih = clamp_side(img_h);
    ww = clamp_side(win_w);
    wh = clamp_side(win_h);
    dx2 = 2 * longint'(px.src_x) - iw;
    dy2 = 2 * longint'(px.src_y) - ih;
    nx = c * dx2 - s * dy2 + iw * (longint'(1) << FRAC_BITS);
    ny = s * dx2 + c * dy2 + ih * (longint'(1) << FRAC_BITS);
    tx = shift_toward_zero(nx);
    ty = shift_toward_zero(ny);
    off = ((wh - ih) / 2) * ww + (ww - iw) / 2;
    addr = ty * ww + tx + off;
    en = !(iw > ww || ih > wh) && addr >= 0 && addr < ww * wh;
    r.write_address = en ? addr[ADDR_W-1:0] : '0;
    r.dest_pixel = px.src_pixel;
    r.write_enable = en;
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] want, logic [63:0] got);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("%0t: mismatch on %s: expected %h, got %h", $time, what, want, got);
  endtask

  always @(posedge clk) begin : check_results
    out_item_t want;
    if (!rst && done) begin
      if (expected_writes.size() == 0) begin
        report_mismatch("unexpected transaction", '0, 64'(result));
      end else begin
        want = expected_writes.pop_front();
        if (result.write_address !== want.write_address)
          report_mismatch("write_address", 64'(want.write_address), 64'(result.write_address));
        if (result.dest_pixel !== want.dest_pixel)
          report_mismatch("dest_pixel", 64'(want.dest_pixel), 64'(result.dest_pixel));
        if (result.write_enable !== want.write_enable)
          report_mismatch("write_enable", 64'(want.write_enable), 64'(result.write_enable));
      end
    end
  end

  task automatic write_register(logic [INDEX_W-1:0] idx, logic [DATA_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    case (idx)
      REG_COSINE:        rot_cos = data;
      REG_SINE:          rot_sin = data;
      REG_IMAGE_WIDTH:   img_w = data[SIDE_W-1:0];
      REG_IMAGE_HEIGHT:  img_h = data[SIDE_W-1:0];
      REG_WINDOW_WIDTH:  win_w = data[SIDE_W-1:0];
      REG_WINDOW_HEIGHT: win_h = data[SIDE_W-1:0];
      default: ;
    endcase
  endtask

  // offset and area are rebuilt in the cycle after a write
  task automatic close_config();
    cfg_we <= 1'b0;
    repeat (2) @(posedge clk);
  endtask

  task automatic apply_config(int c, int s, int iw, int ih, int ww, int wh);
    write_register(REG_COSINE, DATA_W'(c));
    write_register(REG_SINE, DATA_W'(s));
    write_register(REG_IMAGE_WIDTH, DATA_W'(iw));
    write_register(REG_IMAGE_HEIGHT, DATA_W'(ih));
    write_register(REG_WINDOW_WIDTH, DATA_W'(ww));
    write_register(REG_WINDOW_HEIGHT, DATA_W'(wh));
    close_config();
  endtask

  task automatic send_pixel(int x, int y, logic [PIXEL_W-1:0] pix);
    start <= 1'b1;
    item <= '{src_x: COORD_W'(x), src_y: COORD_W'(y), src_pixel: pix};
    @(posedge clk);
    while (busy) @(posedge clk);
    expected_writes.push_back(predict_write(item));
  endtask

  // always waits for a clock edge so start is never lowered and raised in one step
  task automatic wait_for_results();
    int waited;
    start <= 1'b0;
    waited = 0;
    @(posedge clk);
    while (expected_writes.size() != 0 && waited < 64) begin
      @(posedge clk);
      waited++;
    end
    if (expected_writes.size() != 0) begin
      report_mismatch("missing transactions", 64'(expected_writes.size()), '0);
      expected_writes.delete();
    end
  endtask

  task automatic test_reset_identity();
    send_pixel(0, 0, 32'h0000_0000);
    send_pixel(1023, 1023, 32'hffff_ffff);
    send_pixel(1023, 0, 32'h5a5a_a5a5);
    send_pixel(0, 1023, 32'ha5a5_5a5a);
    send_pixel(512, 512, 32'h0123_4567);
    wait_for_results();
  endtask

  task automatic test_quarter_turns();
    apply_config(0, 16384, 64, 48, 256, 128);
    send_pixel(0, 0, 32'h1111_1111);
    send_pixel(63, 47, 32'h2222_2222);
    // position beyond the image still goes through the same mapping
    send_pixel(1023, 1023, 32'h3333_3333);
    wait_for_results();
    apply_config(-16384, 0, 64, 48, 256, 128);
    send_pixel(10, 5, 32'h4444_4444);
    wait_for_results();
    apply_config(0, -16384, 64, 48, 256, 128);
    send_pixel(63, 0, 32'h5555_5555);
    wait_for_results();
  endtask

  task automatic test_oversize_image();
    apply_config(16384, 0, 100, 20, 50, 40);
    send_pixel(10, 10, 32'h6666_6666);
    wait_for_results();
    apply_config(16384, 0, 20, 100, 40, 50);
    send_pixel(5, 5, 32'h7777_7777);
    wait_for_results();
  endtask

  task automatic test_empty_window();
    apply_config(16384, 0, 0, 0, 0, 16);
    send_pixel(0, 0, 32'h8888_8888);
    wait_for_results();
    apply_config(16384, 0, 0, 0, 16, 0);
    send_pixel(0, 0, 32'h9999_9999);
    wait_for_results();
  endtask

  task automatic test_zero_image();
    apply_config(11585, 11585, 0, 0, 32, 32);
    send_pixel(3, 4, 32'haaaa_aaaa);
    send_pixel(0, 0, 32'hbbbb_bbbb);
    wait_for_results();
  endtask

  task automatic test_saturated_sizes();
    apply_config(16384, 0, 2047, 2047, 2047, 2047);
    send_pixel(1023, 1023, 32'hcccc_cccc);
    wait_for_results();
    apply_config(0, 16384, 1025, 1000, 1024, 1024);
    send_pixel(700, 300, 32'hdddd_dddd);
    wait_for_results();
  endtask

  task automatic test_wild_trig();
    apply_config(32767, -32768, 512, 512, 1024, 1024);
    send_pixel(0, 511, 32'heeee_eeee);
    send_pixel(511, 0, 32'hffff_0000);
    wait_for_results();
  endtask

  task automatic test_ignored_index();
    apply_config(16384, 0, 16, 16, 32, 32);
    write_register(REG_SPARE_A, 16'hffff);
    write_register(REG_SPARE_B, 16'h0000);
    close_config();
    send_pixel(15, 15, 32'h0000_ffff);
    wait_for_results();
  endtask

  task automatic test_random_rotations();
    int sent, phase_len, left, burst, mode, c, s, iw, ih, ww, wh, x, y;
    longint span_x, span_y;
    bit gappy;
    logic [PIXEL_W-1:0] pix;
    sent = 0;
    while (sent < 1200) begin
      mode = $urandom_range(0, 99);
      if ($urandom_range(0, 3) == 0) begin
        case ($urandom_range(0, 3))
          0: begin c = 16384;  s = 0;      end
          1: begin c = 0;      s = 16384;  end
          2: begin c = -16384; s = 0;      end
          default: begin c = 0; s = -16384; end
        endcase
      end else begin
        c = int'($urandom_range(0, 32768)) - 16384;
        s = int'($urandom_range(0, 32768)) - 16384;
      end
      if (mode < 70) begin
        if ($urandom_range(0, 4) == 0) begin
          ww = $urandom_range(1, 16);
          wh = $urandom_range(1, 16);
        end else begin
          ww = $urandom_range(1, 1024);
          wh = $urandom_range(1, 1024);
        end
        iw = $urandom_range(1, ww);
        ih = $urandom_range(1, wh);
      end else if (mode < 85) begin
        ww = $urandom_range(1, 1023);
        wh = $urandom_range(1, 1023);
        iw = $urandom_range(1, 1024);
        ih = $urandom_range(1, 1024);
        if (iw <= ww && ih <= wh) iw = $urandom_range(ww + 1, 1024);
      end else begin
        c = $urandom_range(0, 65535);
        s = $urandom_range(0, 65535);
        iw = $urandom_range(0, 65535);
        ih = $urandom_range(0, 65535);
        ww = $urandom_range(0, 65535);
        wh = $urandom_range(0, 65535);
        if ($urandom_range(0, 1) == 0)
          write_register($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B, 16'($urandom));
      end
      apply_config(c, s, iw, ih, ww, wh);
      phase_len = $urandom_range(20, 60);
      gappy = $urandom_range(0, 3) != 0;
      span_x = clamp_side(img_w);
      span_y = clamp_side(img_h);
      left = phase_len;
      while (left > 0) begin
        burst = $urandom_range(1, 24);
        if (burst > left) burst = left;
        repeat (burst) begin
          // mostly positions inside the image, the rest anywhere in the field
          if (span_x > 0 && $urandom_range(0, 3) != 0)
            x = $urandom_range(0, int'(span_x) - 1);
          else
            x = $urandom_range(0, 1023);
          if (span_y > 0 && $urandom_range(0, 3) != 0)
            y = $urandom_range(0, int'(span_y) - 1);
          else
            y = $urandom_range(0, 1023);
          case ($urandom_range(0, 15))
            0: pix = '0;
            1: pix = '1;
            default: pix = $urandom;
          endcase
          send_pixel(x, y, pix);
        end
        left -= burst;
        if (gappy) begin
          if ($urandom_range(0, 29) == 0) begin
            wait_for_results();
          end else begin
            start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
          end
        end
      end
      sent += phase_len;
      wait_for_results();
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_identity();
    test_quarter_turns();
    test_oversize_image();
    test_empty_window();
    test_zero_image();
    test_saturated_sizes();
    test_wild_trig();
    test_ignored_index();
    test_random_rotations();
    wait_for_results();
    repeat (10) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
